// ===== hdl/lpg_pkg.sv =====
// ============================================================================
// Line pixel generator package
// Request and result types, and the line kind codes shared by the design.
// ============================================================================
`default_nettype none

package lpg_pkg;

    // One request: a line load (mode 0) or a request for the next pixel (mode 1).
    typedef struct packed {
        logic       mode;
        logic [6:0] x_start;
        logic [5:0] y_start;
        logic [6:0] x_end;
        logic [5:0] y_end;
        logic       style;
    } t_req;

    // One emitted pixel.
    typedef struct packed {
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic       pixel_on;
        logic       last_pixel;
    } t_res;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // Kind of the line being drawn; idle when no run is active.
    typedef enum logic [2:0] {
        KIND_IDLE = 3'd0,
        KIND_VERT = 3'd1,
        KIND_HORZ = 3'd2,
        KIND_XMAJ = 3'd3,
        KIND_YMAJ = 3'd4
    } t_kind;

endpackage

`default_nettype wire

// ===== hdl/lpg_engine.sv =====
// ============================================================================
// Line pixel generator engine
// Holds the line state, loads new lines and makes one Bresenham step per
// registered pixel request, writing the pixel into the result register.
// ============================================================================
`default_nettype none

module lpg_engine
    import lpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 102,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_vld,
    input  wire t_req i_req,
    output logic      o_res_vld,
    output t_res      o_res
);

    localparam logic [6:0] XMAX = 7'(SCREEN_WIDTH - 1);
    localparam logic [5:0] YMAX = 6'(SCREEN_HEIGHT - 1);

    // Line state.
    logic [6:0]        r_cur_x, n_cur_x, r_tgt_x, n_tgt_x, r_dx, n_dx;
    logic [5:0]        r_cur_y, n_cur_y, r_tgt_y, n_tgt_y, r_dy, n_dy;
    logic signed [9:0] r_err, n_err;
    logic              r_sxn, n_sxn, r_syn, n_syn, r_style, n_style;
    t_kind             r_kind, n_kind;
    logic              r_res_vld, n_res_vld;
    t_res              r_res, n_res;

    // Clamped endpoints and load-time values.
    logic [6:0]        x1, x2, ld_dx;
    logic [5:0]        y1, y2, ld_dy;
    logic              ld_sxn, ld_syn;
    logic signed [9:0] ld_err_x, ld_err_y;

    // Step-time values.
    logic [6:0]        stp_x;
    logic [5:0]        stp_y;
    logic signed [9:0] e_dx2, e_dy2;

    assign x1 = (i_req.x_start > XMAX) ? XMAX : i_req.x_start;
    assign x2 = (i_req.x_end   > XMAX) ? XMAX : i_req.x_end;
    assign y1 = (i_req.y_start > YMAX) ? YMAX : i_req.y_start;
    assign y2 = (i_req.y_end   > YMAX) ? YMAX : i_req.y_end;

    assign ld_sxn = x1 > x2;
    assign ld_syn = y1 > y2;
    assign ld_dx  = ld_sxn ? (x1 - x2) : (x2 - x1);
    assign ld_dy  = ld_syn ? (y1 - y2) : (y2 - y1);

    assign ld_err_x = signed'({3'b000, ld_dy, 1'b0}) - signed'({3'b000, ld_dx});
    assign ld_err_y = signed'({2'b00, ld_dx, 1'b0}) - signed'({4'b0000, ld_dy});

    assign e_dx2 = signed'({2'b00, r_dx, 1'b0});
    assign e_dy2 = signed'({3'b000, r_dy, 1'b0});
    assign stp_x = r_sxn ? (r_cur_x - 7'd1) : (r_cur_x + 7'd1);
    assign stp_y = r_syn ? (r_cur_y - 6'd1) : (r_cur_y + 6'd1);

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_tgt_x   = r_tgt_x;
        n_tgt_y   = r_tgt_y;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_err     = r_err;
        n_sxn     = r_sxn;
        n_syn     = r_syn;
        n_style   = r_style;
        n_kind    = r_kind;
        n_res_vld = 1'b0;
        n_res.pixel_x    = r_cur_x;
        n_res.pixel_y    = r_cur_y;
        n_res.pixel_on   = r_style;
        n_res.last_pixel = 1'b0;

        if (i_req_vld && i_req.mode == MODE_LOAD) begin
            n_style = i_req.style;
            n_sxn   = ld_sxn;
            n_syn   = ld_syn;
            n_dx    = ld_dx;
            n_dy    = ld_dy;
            if (x1 == x2) begin
                n_kind  = KIND_VERT;
                n_cur_x = x1;
                n_tgt_x = x1;
                n_cur_y = ld_syn ? y2 : y1;
                n_tgt_y = ld_syn ? y1 : y2;
                n_err   = '0;
            end else if (y1 == y2) begin
                n_kind  = KIND_HORZ;
                n_cur_y = y1;
                n_tgt_y = y1;
                n_cur_x = ld_sxn ? x2 : x1;
                n_tgt_x = ld_sxn ? x1 : x2;
                n_err   = '0;
            end else begin
                n_cur_x = x1;
                n_cur_y = y1;
                n_tgt_x = x2;
                n_tgt_y = y2;
                if (ld_dx >= {1'b0, ld_dy}) begin
                    n_kind = KIND_XMAJ;
                    n_err  = ld_err_x;
                end else begin
                    n_kind = KIND_YMAJ;
                    n_err  = ld_err_y;
                end
            end
        end else if (i_req_vld && i_req.mode == MODE_STEP) begin
            case (r_kind)
                KIND_VERT: begin
                    n_res_vld = 1'b1;
                    if (r_cur_y == r_tgt_y) begin
                        n_res.last_pixel = 1'b1;
                    end else begin
                        n_cur_y = r_cur_y + 6'd1;
                    end
                end
                KIND_HORZ: begin
                    n_res_vld = 1'b1;
                    if (r_cur_x == r_tgt_x) begin
                        n_res.last_pixel = 1'b1;
                    end else begin
                        n_cur_x = r_cur_x + 7'd1;
                    end
                end
                KIND_XMAJ: begin
                    n_res_vld = 1'b1;
                    if (r_err < 0) begin
                        n_err = r_err + e_dy2;
                    end else begin
                        n_err   = r_err + e_dy2 - e_dx2;
                        n_cur_y = stp_y;
                    end
                    n_cur_x = stp_x;
                    n_res.last_pixel = (stp_x == r_tgt_x);
                end
                KIND_YMAJ: begin
                    n_res_vld = 1'b1;
                    if (r_err < 0) begin
                        n_err = r_err + e_dx2;
                    end else begin
                        n_err   = r_err + e_dx2 - e_dy2;
                        n_cur_x = stp_x;
                    end
                    n_cur_y = stp_y;
                    n_res.last_pixel = (stp_y == r_tgt_y);
                end
                default: begin
                    n_res_vld = 1'b0;
                end
            endcase
            if (n_res.last_pixel) begin
                n_kind = KIND_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= KIND_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_kind    <= n_kind;
            r_res_vld <= n_res_vld;
        end
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_tgt_x <= n_tgt_x;
        r_tgt_y <= n_tgt_y;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_err   <= n_err;
        r_sxn   <= n_sxn;
        r_syn   <= n_syn;
        r_style <= n_style;
        r_res   <= n_res;
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    // A pixel only follows a registered pixel request.
    a_res_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> $past(i_req_vld && i_req.mode == MODE_STEP))
        else $error("pixel emitted without a pixel request");

    // A load never produces a pixel.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_vld && i_req.mode == MODE_LOAD) |=> !r_res_vld)
        else $error("pixel emitted for a line load");

    // The last pixel of a run leaves the engine idle.
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.last_pixel) |-> r_kind == KIND_IDLE)
        else $error("engine still active after the last pixel");

    // Emitted pixels lie on the screen.
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_vld |-> (r_res.pixel_x <= XMAX && r_res.pixel_y <= YMAX))
        else $error("pixel outside the screen");

endmodule

`default_nettype wire

// ===== hdl/line_pixel_generator_unit.sv =====
// ============================================================================
// Line pixel generator unit
// Bresenham line rasterizer for a small monochrome display.
// ============================================================================
// A request with mode 0 loads a line: both endpoints are clamped to the
// screen, the style bit is latched, and nothing is emitted. Each later
// request with mode 1 emits one pixel of that line on o_res, marked by a
// single-cycle o_res_valid strobe, with last_pixel set on the final pixel;
// a pixel request while no line is active is dropped. Vertical and
// horizontal lines cover both endpoints in ascending order, whilst sloped
// lines run from the start point and stop one pixel short of the end point.
// A request is taken on every cycle that start is high: busy never rises,
// since each request is handled in one pass through the stepping logic
// between the request register and the result register. The pixel for a
// request passes through the request register and then the result register,
// so results come back in request order at up to one per cycle. The
// receiver cannot stall, so it must capture every strobed result when it
// appears.
// ============================================================================
`default_nettype none

module line_pixel_generator_unit
    import lpg_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 102,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_res_valid,
    output t_res      o_res
);

    // Request register: holds the accepted request for the engine.
    logic r_req_vld;
    t_req r_req;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // The engine updates the line state and registers the emitted pixel.
    lpg_engine #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (r_req_vld),
        .i_req     (r_req),
        .o_res_vld (o_res_valid),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire
